// ===== rtl/ctb_pkg.sv =====
// Package for the countdown timer bank: item types, action and result codes,
// and the default bank sizes.
// Depends on nothing; used by countdown_timer_bank_unit.
package ctb_pkg;

   localparam int ACTION_W = 4;
   localparam int SLOT_W   = 5;
   localparam int DATA_W   = 32;
   localparam int KIND_W   = 3;

   localparam int NUM_ONESHOT_DEF  = 16;
   localparam int NUM_PERIODIC_DEF = 8;

   localparam logic [ACTION_W-1:0] ACT_TICK        = 4'd0;
   localparam logic [ACTION_W-1:0] ACT_START_OS    = 4'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY       = 4'd2;
   localparam logic [ACTION_W-1:0] ACT_READ_OS     = 4'd3;
   localparam logic [ACTION_W-1:0] ACT_ALLOC       = 4'd4;
   localparam logic [ACTION_W-1:0] ACT_FREE        = 4'd5;
   localparam logic [ACTION_W-1:0] ACT_START_PR    = 4'd6;
   localparam logic [ACTION_W-1:0] ACT_STOP        = 4'd7;
   localparam logic [ACTION_W-1:0] ACT_RESET_PR    = 4'd8;
   localparam logic [ACTION_W-1:0] ACT_READ_MS     = 4'd9;
   localparam logic [ACTION_W-1:0] ACT_READ_MISUSE = 4'd10;

   localparam logic [KIND_W-1:0] KIND_ACK    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FIRE   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS = 3'd2;
   localparam logic [KIND_W-1:0] KIND_VALUE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd4;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SLOT_W-1:0]   slot_index;
      logic [DATA_W-1:0]   load_value;
      logic                clear_request;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] result_kind;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] data;
      logic              status_bit;
      logic              last;
   } rsp_type;

endpackage

// ===== rtl/countdown_timer_bank_unit.sv =====
// Countdown timer bank: one-shot timers and periodic auto-reload timers.
// Depends on ctb_pkg for item types and codes.
// A tick walks every one-shot timer and then every periodic timer through the
// one shared decrementer and ends with an acknowledge; a fire result that meets
// a full output register stalls the walk. Other commands give one result each;
// an allocation scans the periodic slots. One item is in work at a time.
// Reset (synchronous) clears all counters, flags and the millisecond count.
module countdown_timer_bank_unit #(
   parameter int NUM_ONESHOT  = ctb_pkg::NUM_ONESHOT_DEF,
   parameter int NUM_PERIODIC = ctb_pkg::NUM_PERIODIC_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ctb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ctb_pkg::rsp_type rsp_data
);

   localparam int OS_IDX_W = (NUM_ONESHOT > 1) ? $clog2(NUM_ONESHOT) : 1;
   localparam int PR_IDX_W = (NUM_PERIODIC > 1) ? $clog2(NUM_PERIODIC) : 1;
   localparam int WALK_MAX = (NUM_ONESHOT > NUM_PERIODIC) ? NUM_ONESHOT : NUM_PERIODIC;
   localparam int WALK_W   = $clog2(WALK_MAX + 1);
   localparam int SW1      = ctb_pkg::SLOT_W + 1;
   localparam int DW       = ctb_pkg::DATA_W;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CMD      = 3'd1;
   localparam logic [2:0] S_OS_WALK  = 3'd2;
   localparam logic [2:0] S_PR_WALK  = 3'd3;
   localparam logic [2:0] S_TICK_ACK = 3'd4;
   localparam logic [2:0] S_ALLOC    = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [WALK_W-1:0]       walk_ff, walk_in;
   ctb_pkg::req_type        req_ff, req_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ctb_pkg::rsp_type        rsp_ff, rsp_in;
   logic [DW-1:0]           os_count_ff [NUM_ONESHOT];
   logic [DW-1:0]           os_count_in [NUM_ONESHOT];
   logic [NUM_ONESHOT-1:0]  os_exp_ff, os_exp_in;
   logic [DW-1:0]           pr_count_ff [NUM_PERIODIC];
   logic [DW-1:0]           pr_count_in [NUM_PERIODIC];
   logic [DW-1:0]           pr_reload_ff [NUM_PERIODIC];
   logic [DW-1:0]           pr_reload_in [NUM_PERIODIC];
   logic [NUM_PERIODIC-1:0] pr_en_ff, pr_en_in;
   logic [NUM_PERIODIC-1:0] pr_arm_ff, pr_arm_in;
   logic [DW-1:0]           ms_ff, ms_in;
   logic                    misuse_ff, misuse_in;

   logic                    out_free;
   logic                    os_ok;
   logic                    pr_ok;
   logic [OS_IDX_W-1:0]     os_addr;
   logic [PR_IDX_W-1:0]     req_pr_idx;
   logic [PR_IDX_W-1:0]     walk_pr_idx;
   logic [DW-1:0]           unit_val;
   logic [DW-1:0]           unit_dec;
   logic                    unit_zero;
   logic                    walk_last_os;
   logic                    walk_last_pr;
   logic                    pr_active;
   logic                    qry_exp;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign os_ok       = {1'b0, req_ff.slot_index} < SW1'(NUM_ONESHOT);
   assign pr_ok       = {1'b0, req_ff.slot_index} < SW1'(NUM_PERIODIC);
   assign req_pr_idx  = req_ff.slot_index[PR_IDX_W-1:0];
   assign walk_pr_idx = walk_ff[PR_IDX_W-1:0];
   assign os_addr     = (state_ff == S_OS_WALK) ? walk_ff[OS_IDX_W-1:0]
                                                : req_ff.slot_index[OS_IDX_W-1:0];

   // The shared unit: one read port, one zero compare and one decrementer.
   assign unit_val  = (state_ff == S_PR_WALK) ? pr_count_ff[walk_pr_idx]
                                              : os_count_ff[os_addr];
   assign unit_dec  = unit_val - DW'(1);
   assign unit_zero = (unit_val == '0);

   assign walk_last_os = (walk_ff == WALK_W'(NUM_ONESHOT - 1));
   assign walk_last_pr = (walk_ff == WALK_W'(NUM_PERIODIC - 1));
   assign pr_active    = pr_arm_ff[walk_pr_idx] && pr_en_ff[walk_pr_idx];
   assign qry_exp      = os_ok && os_exp_ff[os_addr];

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      os_count_in  = os_count_ff;
      os_exp_in    = os_exp_ff;
      pr_count_in  = pr_count_ff;
      pr_reload_in = pr_reload_ff;
      pr_en_in     = pr_en_ff;
      pr_arm_in    = pr_arm_ff;
      ms_in        = ms_ff;
      misuse_in    = misuse_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               walk_in = '0;
               if (req_data.action == ctb_pkg::ACT_TICK) begin
                  ms_in    = ms_ff + DW'(1);
                  state_in = S_OS_WALK;
               end else if (req_data.action == ctb_pkg::ACT_ALLOC) begin
                  state_in = S_ALLOC;
               end else begin
                  state_in = S_CMD;
               end
            end
         end
         S_CMD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.last  = 1'b1;
               state_in     = S_IDLE;
               unique case (req_ff.action)
                  ctb_pkg::ACT_START_OS: begin
                     if (os_ok && (unit_val != req_ff.load_value)) begin
                        os_count_in[os_addr] = req_ff.load_value;
                        os_exp_in[os_addr]   = (req_ff.load_value == '0);
                     end
                  end
                  ctb_pkg::ACT_QUERY: begin
                     rsp_in.result_kind = ctb_pkg::KIND_STATUS;
                     rsp_in.slot        = req_ff.slot_index;
                     rsp_in.status_bit  = qry_exp;
                     if (qry_exp && req_ff.clear_request) begin
                        os_exp_in[os_addr] = 1'b0;
                     end
                  end
                  ctb_pkg::ACT_READ_OS: begin
                     rsp_in.result_kind = ctb_pkg::KIND_VALUE;
                     rsp_in.slot        = req_ff.slot_index;
                     rsp_in.data        = os_ok ? unit_val : '0;
                  end
                  ctb_pkg::ACT_FREE: begin
                     if (!pr_ok) begin
                        misuse_in = 1'b1;
                     end else begin
                        pr_en_in[req_pr_idx]  = 1'b0;
                        pr_arm_in[req_pr_idx] = 1'b0;
                     end
                  end
                  ctb_pkg::ACT_START_PR: begin
                     if (!pr_ok) begin
                        misuse_in = 1'b1;
                     end else begin
                        pr_count_in[req_pr_idx]  = req_ff.load_value;
                        pr_reload_in[req_pr_idx] = req_ff.load_value;
                        pr_arm_in[req_pr_idx]    = 1'b1;
                     end
                  end
                  ctb_pkg::ACT_STOP: begin
                     if (!pr_ok) begin
                        misuse_in = 1'b1;
                     end else begin
                        pr_arm_in[req_pr_idx] = 1'b0;
                     end
                  end
                  ctb_pkg::ACT_RESET_PR: begin
                     pr_en_in  = '0;
                     pr_arm_in = '0;
                  end
                  ctb_pkg::ACT_READ_MS: begin
                     rsp_in.result_kind = ctb_pkg::KIND_VALUE;
                     rsp_in.data        = ms_ff;
                  end
                  ctb_pkg::ACT_READ_MISUSE: begin
                     rsp_in.result_kind = ctb_pkg::KIND_VALUE;
                     rsp_in.data        = DW'(misuse_ff);
                     rsp_in.status_bit  = misuse_ff;
                     misuse_in          = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_OS_WALK: begin
            if (!unit_zero) begin
               os_count_in[os_addr] = unit_dec;
               if (unit_dec == '0) begin
                  os_exp_in[os_addr] = 1'b1;
               end
            end
            if (walk_last_os) begin
               walk_in  = '0;
               state_in = S_PR_WALK;
            end else begin
               walk_in = walk_ff + WALK_W'(1);
            end
         end
         S_PR_WALK: begin
            if (!(pr_active && unit_zero) || out_free) begin
               if (pr_active && unit_zero) begin
                  pr_count_in[walk_pr_idx] = pr_reload_ff[walk_pr_idx];
                  rsp_valid_in       = 1'b1;
                  rsp_in             = '0;
                  rsp_in.result_kind = ctb_pkg::KIND_FIRE;
                  rsp_in.slot        = ctb_pkg::SLOT_W'(walk_ff);
               end else if (pr_active) begin
                  pr_count_in[walk_pr_idx] = unit_dec;
               end
               if (walk_last_pr) begin
                  state_in = S_TICK_ACK;
               end else begin
                  walk_in = walk_ff + WALK_W'(1);
               end
            end
         end
         S_TICK_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.last  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_ALLOC: begin
            if (walk_ff == WALK_W'(NUM_PERIODIC)) begin
               if (out_free) begin
                  misuse_in          = 1'b1;
                  rsp_valid_in       = 1'b1;
                  rsp_in             = '0;
                  rsp_in.result_kind = ctb_pkg::KIND_ALLOC;
                  rsp_in.slot        = ctb_pkg::SLOT_W'(NUM_PERIODIC);
                  rsp_in.last        = 1'b1;
                  state_in           = S_IDLE;
               end
            end else if (!pr_en_ff[walk_pr_idx]) begin
               if (out_free) begin
                  pr_en_in[walk_pr_idx]  = 1'b1;
                  pr_arm_in[walk_pr_idx] = 1'b0;
                  rsp_valid_in       = 1'b1;
                  rsp_in             = '0;
                  rsp_in.result_kind = ctb_pkg::KIND_ALLOC;
                  rsp_in.slot        = ctb_pkg::SLOT_W'(walk_ff);
                  rsp_in.status_bit  = 1'b1;
                  rsp_in.last        = 1'b1;
                  state_in           = S_IDLE;
               end
            end else begin
               walk_in = walk_ff + WALK_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_ONESHOT; i++) begin
            os_count_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_PERIODIC; i++) begin
            pr_count_ff[i]  <= '0;
            pr_reload_ff[i] <= '0;
         end
         os_exp_ff <= '0;
         pr_en_ff  <= '0;
         pr_arm_ff <= '0;
         ms_ff     <= '0;
         misuse_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
         os_count_ff  <= os_count_in;
         pr_count_ff  <= pr_count_in;
         pr_reload_ff <= pr_reload_in;
         os_exp_ff    <= os_exp_in;
         pr_en_ff     <= pr_en_in;
         pr_arm_ff    <= pr_arm_in;
         ms_ff        <= ms_in;
         misuse_ff    <= misuse_in;
      end
   end

endmodule

// ===== sim/tb_countdown_timer_bank_unit.sv =====
// Self-checking testbench for countdown_timer_bank_unit: directed and random command
// items are checked against a behavioral model of the one-shot and periodic timers.
// Depends on ctb_pkg and the RTL of countdown_timer_bank_unit.
module tb_countdown_timer_bank_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ctb_pkg::*;

   localparam int NUM_OS = NUM_ONESHOT_DEF;
   localparam int NUM_PR = NUM_PERIODIC_DEF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 10;
   int stall_pct = 83;
   int mismatch_count = 0;

   rsp_type due_results[$];

   logic [DATA_W-1:0] os_count[NUM_OS];
   logic              os_expired[NUM_OS];
   logic [DATA_W-1:0] pr_count[NUM_PR];
   logic [DATA_W-1:0] pr_reload[NUM_PR];
   logic              pr_enabled[NUM_PR];
   logic              pr_armed[NUM_PR];
   logic [DATA_W-1:0] ms_ticks;
   logic              misuse;

   countdown_timer_bank_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_countdown_timer_bank_unit: errors");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Works out the result items of one accepted command and updates the timer state.
   function automatic void predict_timer_bank(input req_type it);
      rsp_type r;
      int      i;
      int      found;
      logic    os_ok;
      logic    pr_ok;
      os_ok = it.slot_index < NUM_OS;
      pr_ok = it.slot_index < NUM_PR;
      r = '0;
      case (it.action)
         ACT_TICK: begin
            ms_ticks = ms_ticks + 1;
            for (i = 0; i < NUM_OS; i++) begin
               if (os_count[i] != 0) begin
                  os_count[i] = os_count[i] - 1;
                  if (os_count[i] == 0) os_expired[i] = 1'b1;
               end
            end
            for (i = 0; i < NUM_PR; i++) begin
               if (pr_armed[i] && pr_enabled[i]) begin
                  if (pr_count[i] == 0) begin
                     pr_count[i] = pr_reload[i];
                     r = '0;
                     r.result_kind = KIND_FIRE;
                     r.slot = SLOT_W'(i);
                     due_results.push_back(r);
                  end else begin
                     pr_count[i] = pr_count[i] - 1;
                  end
               end
            end
            r = '0;
            r.result_kind = KIND_ACK;
         end
         ACT_START_OS: begin
            if (os_ok && os_count[it.slot_index] != it.load_value) begin
               os_count[it.slot_index] = it.load_value;
               os_expired[it.slot_index] = (it.load_value == 0);
            end
            r.result_kind = KIND_ACK;
         end
         ACT_QUERY: begin
            r.result_kind = KIND_STATUS;
            r.slot = it.slot_index;
            if (os_ok && os_expired[it.slot_index]) begin
               r.status_bit = 1'b1;
               if (it.clear_request) os_expired[it.slot_index] = 1'b0;
            end
         end
         ACT_READ_OS: begin
            r.result_kind = KIND_VALUE;
            r.slot = it.slot_index;
            r.data = os_ok ? os_count[it.slot_index] : '0;
         end
         ACT_ALLOC: begin
            found = NUM_PR;
            for (i = NUM_PR - 1; i >= 0; i--) begin
               if (!pr_enabled[i]) found = i;
            end
            r.result_kind = KIND_ALLOC;
            r.slot = SLOT_W'(found);
            if (found < NUM_PR) begin
               pr_enabled[found] = 1'b1;
               pr_armed[found] = 1'b0;
               r.status_bit = 1'b1;
            end else begin
               misuse = 1'b1;
            end
         end
         ACT_FREE, ACT_START_PR, ACT_STOP: begin
            if (!pr_ok) begin
               misuse = 1'b1;
            end else if (it.action == ACT_FREE) begin
               pr_enabled[it.slot_index] = 1'b0;
               pr_armed[it.slot_index] = 1'b0;
            end else if (it.action == ACT_START_PR) begin
               pr_count[it.slot_index] = it.load_value;
               pr_reload[it.slot_index] = it.load_value;
               pr_armed[it.slot_index] = 1'b1;
            end else begin
               pr_armed[it.slot_index] = 1'b0;
            end
            r.result_kind = KIND_ACK;
         end
         ACT_RESET_PR: begin
            for (i = 0; i < NUM_PR; i++) begin
               pr_enabled[i] = 1'b0;
               pr_armed[i] = 1'b0;
            end
            r.result_kind = KIND_ACK;
         end
         ACT_READ_MS: begin
            r.result_kind = KIND_VALUE;
            r.data = ms_ticks;
         end
         ACT_READ_MISUSE: begin
            r.result_kind = KIND_VALUE;
            r.data = DATA_W'(misuse);
            r.status_bit = misuse;
            misuse = 1'b0;
         end
         default: begin
            r.result_kind = KIND_ACK;
         end
      endcase
      r.last = 1'b1;
      due_results.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                       input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $error("result item with no expectation: kind %0d slot %0d data %0h",
                   rsp_data.result_kind, rsp_data.slot, rsp_data.data);
            mismatch_count++;
         end else begin
            want = due_results.pop_front();
            check_field("result_kind", DATA_W'(want.result_kind),
                        DATA_W'(rsp_data.result_kind));
            check_field("slot", DATA_W'(want.slot), DATA_W'(rsp_data.slot));
            check_field("data", want.data, rsp_data.data);
            check_field("status_bit", DATA_W'(want.status_bit), DATA_W'(rsp_data.status_bit));
            check_field("last", DATA_W'(want.last), DATA_W'(rsp_data.last));
         end
      end
   end

   // The valid line stays high after an item is taken so that a following item can go
   // out on the next edge; it is lowered only when a gap or a pause begins.
   task automatic send_item(input logic [ACTION_W-1:0] action, input logic [SLOT_W-1:0] slot,
                            input logic [DATA_W-1:0] value, input logic clr);
      req_type it;
      it.action = action;
      it.slot_index = slot;
      it.load_value = value;
      it.clear_request = clr;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      predict_timer_bank(it);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
   endtask

   task automatic test_oneshot_timers();
      send_item(ACT_START_OS, 5'd1, 32'd2, 1'b0);
      send_item(ACT_START_OS, 5'd15, 32'hFFFF_FFFF, 1'b0);
      send_item(ACT_START_OS, 5'd31, 32'd5, 1'b0);
      send_item(ACT_START_OS, 5'd0, 32'd0, 1'b0);
      send_item(ACT_TICK, 5'd0, 32'd0, 1'b0);
      send_item(ACT_TICK, 5'd31, 32'hFFFF_FFFF, 1'b1);
      send_item(ACT_QUERY, 5'd1, 32'd0, 1'b1);
      send_item(ACT_QUERY, 5'd1, 32'd0, 1'b0);
      send_item(ACT_READ_OS, 5'd15, 32'd0, 1'b0);
      send_item(ACT_READ_OS, 5'd31, 32'd0, 1'b0);
      send_item(ACT_START_OS, 5'd15, 32'd0, 1'b0);
      send_item(ACT_QUERY, 5'd15, 32'd0, 1'b1);
   endtask

   task automatic test_periodic_pool();
      send_item(ACT_START_PR, 5'd7, 32'd0, 1'b0);
      repeat (NUM_PR + 1) send_item(ACT_ALLOC, 5'd0, 32'd0, 1'b0);
      send_item(ACT_START_PR, 5'd0, 32'd0, 1'b0);
      send_item(ACT_START_PR, 5'd3, 32'd1, 1'b0);
      send_item(ACT_TICK, 5'd0, 32'd0, 1'b0);
      send_item(ACT_TICK, 5'd0, 32'd0, 1'b0);
      send_item(ACT_START_PR, 5'd31, 32'd2, 1'b0);
      send_item(ACT_STOP, 5'd0, 32'd0, 1'b0);
      send_item(ACT_FREE, 5'd3, 32'd0, 1'b0);
      send_item(ACT_RESET_PR, 5'd9, 32'd0, 1'b0);
   endtask

   task automatic test_status_reads();
      send_item(ACT_READ_MISUSE, 5'd0, 32'd0, 1'b0);
      send_item(ACT_READ_MISUSE, 5'd0, 32'd0, 1'b0);
      send_item(ACT_READ_MS, 5'd0, 32'd0, 1'b0);
      send_item(4'd15, 5'd31, 32'hFFFF_FFFF, 1'b1);
   endtask

   // Mostly ticks and well-formed commands on small counts so that timers expire and
   // periodic slots fire often; a few items carry full-range fields or any action code.
   task automatic test_random_traffic(input int count);
      int                  n;
      int                  pick;
      logic [ACTION_W-1:0] action;
      logic [SLOT_W-1:0]   slot;
      logic [DATA_W-1:0]   value;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 38) action = ACT_TICK;
         else if (pick < 50) action = ACT_START_OS;
         else if (pick < 58) action = ACT_QUERY;
         else if (pick < 64) action = ACT_READ_OS;
         else if (pick < 72) action = ACT_ALLOC;
         else if (pick < 80) action = ACT_START_PR;
         else if (pick < 84) action = ACT_STOP;
         else if (pick < 87) action = ACT_FREE;
         else if (pick < 89) action = ACT_RESET_PR;
         else if (pick < 92) action = ACT_READ_MS;
         else if (pick < 95) action = ACT_READ_MISUSE;
         else action = ACTION_W'($urandom_range(15));
         if ($urandom_range(9) == 0) slot = SLOT_W'($urandom_range(31));
         else if (action >= ACT_ALLOC) slot = SLOT_W'($urandom_range(NUM_PR - 1));
         else slot = SLOT_W'($urandom_range(NUM_OS - 1));
         if ($urandom_range(15) == 0) value = $urandom();
         else value = $urandom_range(5);
         send_item(action, slot, value, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      os_count = '{default: '0};
      os_expired = '{default: 1'b0};
      pr_count = '{default: '0};
      pr_reload = '{default: '0};
      pr_enabled = '{default: 1'b0};
      pr_armed = '{default: 1'b0};
      ms_ticks = '0;
      misuse = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 10;
      stall_pct = 83;
      test_oneshot_timers();
      test_periodic_pool();
      test_status_reads();
      test_random_traffic(52);
      wait_drained();

      send_idle_pct = 83;
      stall_pct = 10;
      test_random_traffic(52);
      wait_drained();

      send_idle_pct = 0;
      stall_pct = 0;
      test_random_traffic(52);
      wait_drained();

      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_countdown_timer_bank_unit: clean");
      end else begin
         $display("tb_countdown_timer_bank_unit: errors");
      end
      $finish;
   end

endmodule
